/* src/wavh_pkg.sv */
// ---------------------------------------------------------------------------
// wavh_pkg
// Shared types, status codes and constants of the WAV header checker.
// ---------------------------------------------------------------------------
`default_nettype none

package wavh_pkg;

    localparam int LENGTH_WIDTH_DEF = 32;

    // register indexes of the configuration port
    localparam logic [2:0] CFG_CHANNELS    = 3'd0;
    localparam logic [2:0] CFG_SAMPLE_RATE = 3'd1;
    localparam logic [2:0] CFG_BYTE_RATE   = 3'd2;
    localparam logic [2:0] CFG_FRAME_BYTES = 3'd3;
    localparam logic [2:0] CFG_SAMPLE_BITS = 3'd4;

    // result status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_NOT_WAVE    = 3'd1;
    localparam logic [2:0] ST_SECOND_FMT  = 3'd2;
    localparam logic [2:0] ST_BAD_FMT_LEN = 3'd3;
    localparam logic [2:0] ST_FMT_DIFFER  = 3'd4;
    localparam logic [2:0] ST_SECOND_DATA = 3'd5;
    localparam logic [2:0] ST_MISSING     = 3'd6;
    localparam logic [2:0] ST_TOO_LONG    = 3'd7;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [4:0]  FMT_BODY_BYTES = 5'd16;
    localparam logic [15:0] PCM_FORMAT_TAG = 16'd1;
    localparam logic [32:0] FIRST_CHUNK    = 33'd12;
    localparam logic [32:0] START_SAT      = 33'h1_FFFF_FFFF;

    localparam logic [15:0] RST_CHANNELS    = 16'd1;
    localparam logic [31:0] RST_SAMPLE_RATE = 32'd44100;
    localparam logic [31:0] RST_BYTE_RATE   = 32'd88200;
    localparam logic [15:0] RST_FRAME_BYTES = 16'd2;
    localparam logic [15:0] RST_SAMPLE_BITS = 16'd16;

    typedef struct packed {
        logic [15:0] channels;
        logic [31:0] sample_rate;
        logic [31:0] byte_rate;
        logic [15:0] frame_bytes;
        logic [15:0] sample_bits;
    } t_cfg;

    // one classified byte as it travels from the front to the back
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_file;
        logic       saturated;   // count already at its limit
        logic       short_file;  // fewer than 12 bytes counted after this one
        logic       at_riff;     // last byte of the RIFF tag
        logic       at_wave;     // last byte of the WAVE tag
    } t_item;

endpackage

`default_nettype wire

/* src/wavh_in_if.sv */
// ---------------------------------------------------------------------------
// wavh_in_if
// Byte stream channel into the WAV header checker.
// ---------------------------------------------------------------------------
`default_nettype none

interface wavh_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_file;

    modport source (output valid, output in_byte, output end_of_file, input ready);
    modport sink   (input valid, input in_byte, input end_of_file, output ready);
endinterface

`default_nettype wire

/* src/wavh_out_if.sv */
// ---------------------------------------------------------------------------
// wavh_out_if
// Result channel of the WAV header checker.
// ---------------------------------------------------------------------------
`default_nettype none

interface wavh_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] audio_start;
    logic [31:0] audio_len;

    modport source (output valid, output status, output audio_start, output audio_len,
                    input ready);
    modport sink   (input valid, input status, input audio_start, input audio_len,
                    output ready);
endinterface

`default_nettype wire

/* src/wavh_front.sv */
// ---------------------------------------------------------------------------
// wavh_front
// Accepts file bytes, keeps the byte position and tags each byte with its
// position classes before it goes to the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module wavh_front
    import wavh_pkg::*;
#(
    parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    wavh_in_if.sink                  i_in,
    input  wire                      i_q_full,
    output logic                     o_push,
    output t_item                    o_item,
    output logic [LENGTH_WIDTH-1:0]  o_pos
);

    logic [LENGTH_WIDTH-1:0] r_pos;
    logic [LENGTH_WIDTH-1:0] n_pos;
    logic                    w_sat;

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;
    assign w_sat      = &r_pos;

    always_comb begin
        o_item.in_byte     = i_in.in_byte;
        o_item.end_of_file = i_in.end_of_file;
        o_item.saturated   = w_sat;
        o_item.short_file  = !w_sat && (r_pos < LENGTH_WIDTH'(11));
        o_item.at_riff     = (r_pos == LENGTH_WIDTH'(3));
        o_item.at_wave     = (r_pos == LENGTH_WIDTH'(11));
        o_pos              = r_pos;
    end

    always_comb begin
        n_pos = r_pos;
        if (o_push) begin
            if (i_in.end_of_file) begin
                n_pos = '0;
            end else if (!w_sat) begin
                n_pos = r_pos + LENGTH_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

`default_nettype wire

/* src/wavh_fifo.sv */
// ---------------------------------------------------------------------------
// wavh_fifo
// Two-entry queue between the front and the back.
// ---------------------------------------------------------------------------
`default_nettype none

module wavh_fifo
    import wavh_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  wire [WIDTH-1:0]  i_data,
    input  wire              i_pop,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic [1:0]       n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

/* src/wavh_back.sv */
// ---------------------------------------------------------------------------
// wavh_back
// Walks the chunk structure one queued byte per cycle unless o_out holds off
// its result, checks the tags and the fmt body, latches the first error and
// registers the result.
`default_nettype none

module wavh_back
    import wavh_pkg::*;
#(
    parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  t_cfg                    i_cfg,
    input  wire                     i_q_valid,
    input  t_item                   i_item,
    input  wire [LENGTH_WIDTH-1:0]  i_pos,
    output logic                    o_pop,
    wavh_out_if.source              o_out
);

    localparam int CMP_W = 34;

    logic [63:0]  r_tag,   n_tag;
    logic [127:0] r_fmt,   n_fmt;
    logic [4:0]   r_left,  n_left;
    logic         r_seen_fmt, n_seen_fmt;
    logic         r_seen_data, n_seen_data;
    logic [2:0]   r_err,   n_err;
    logic [32:0]  r_next,  n_next;
    logic [31:0]  r_start, n_start;
    logic [31:0]  r_len,   n_len;

    logic         r_out_valid;
    logic [2:0]   r_out_status;
    logic [31:0]  r_out_offset;
    logic [31:0]  r_out_size;

    logic [31:0]      w_size;
    logic [CMP_W-1:0] w_sum;
    logic             w_hdr;
    logic             w_fmt_bad;
    logic [2:0]       w_status;

    assign o_pop = i_q_valid && (!r_out_valid || o_out.ready);

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out_status;
    assign o_out.audio_start = r_out_offset;
    assign o_out.audio_len   = r_out_size;

    always_comb begin
        n_tag       = r_tag;
        n_fmt       = r_fmt;
        n_left      = r_left;
        n_seen_fmt  = r_seen_fmt;
        n_seen_data = r_seen_data;
        n_err       = r_err;
        n_next      = r_next;
        n_start     = r_start;
        n_len       = r_len;
        w_fmt_bad   = 1'b0;

        n_tag  = {r_tag[55:0], i_item.in_byte};
        w_size = {n_tag[7:0], n_tag[15:8], n_tag[23:16], n_tag[31:24]};
        w_sum  = {1'b0, r_next} + CMP_W'(8) + CMP_W'(w_size);
        w_hdr  = (({1'b0, r_next} + CMP_W'(7)) == CMP_W'(i_pos));

        if (i_item.saturated) begin
            n_tag = r_tag;
            if (n_err == ST_OK) begin
                n_err = ST_TOO_LONG;
            end
        end else begin
            // fmt body: shift bytes in, check the fields on the last one
            if (r_left != 5'd0) begin
                n_fmt  = {i_item.in_byte, r_fmt[127:8]};
                n_left = r_left - 5'd1;
                if (n_left == 5'd0) begin
                    w_fmt_bad = (n_fmt[15:0]    != PCM_FORMAT_TAG)     ||
                                (n_fmt[31:16]   != i_cfg.channels)     ||
                                (n_fmt[63:32]   != i_cfg.sample_rate)  ||
                                (n_fmt[95:64]   != i_cfg.byte_rate)    ||
                                (n_fmt[111:96]  != i_cfg.frame_bytes)  ||
                                (n_fmt[127:112] != i_cfg.sample_bits);
                    if (w_fmt_bad && n_err == ST_OK) begin
                        n_err = ST_FMT_DIFFER;
                    end
                end
            end
            if (i_item.at_riff && n_tag[31:0] != TAG_RIFF && n_err == ST_OK) begin
                n_err = ST_NOT_WAVE;
            end
            if (i_item.at_wave && n_tag[31:0] != TAG_WAVE && n_err == ST_OK) begin
                n_err = ST_NOT_WAVE;
            end
            if (w_hdr) begin
                if (n_tag[63:32] == TAG_FMT) begin
                    if (r_seen_fmt && n_err == ST_OK) begin
                        n_err = ST_SECOND_FMT;
                    end
                    n_seen_fmt = 1'b1;
                    if (w_size != 32'(FMT_BODY_BYTES)) begin
                        if (n_err == ST_OK) begin
                            n_err = ST_BAD_FMT_LEN;
                        end
                    end else begin
                        n_left = FMT_BODY_BYTES;
                    end
                end else if (n_tag[63:32] == TAG_DATA) begin
                    if (r_seen_data && n_err == ST_OK) begin
                        n_err = ST_SECOND_DATA;
                    end
                    n_seen_data = 1'b1;
                    n_start     = r_next[31:0] + 32'd8;
                    n_len       = w_size;
                end
                // saturate so that no later header can match
                if (w_sum > CMP_W'(START_SAT)) begin
                    n_next = START_SAT;
                end else begin
                    n_next = w_sum[32:0];
                end
            end
        end

        w_status = n_err;
        if (w_status == ST_OK) begin
            if (i_item.short_file) begin
                w_status = ST_NOT_WAVE;
            end else if (n_left != 5'd0) begin
                w_status = ST_FMT_DIFFER;
            end else if (!n_seen_fmt || !n_seen_data) begin
                w_status = ST_MISSING;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag       <= '0;
            r_fmt       <= '0;
            r_left      <= 5'd0;
            r_seen_fmt  <= 1'b0;
            r_seen_data <= 1'b0;
            r_err       <= ST_OK;
            r_next      <= FIRST_CHUNK;
            r_start     <= '0;
            r_len       <= '0;
        end else if (o_pop) begin
            if (i_item.end_of_file) begin
                // end of file: start over for the next one
                r_tag       <= '0;
                r_fmt       <= '0;
                r_left      <= 5'd0;
                r_seen_fmt  <= 1'b0;
                r_seen_data <= 1'b0;
                r_err       <= ST_OK;
                r_next      <= FIRST_CHUNK;
                r_start     <= '0;
                r_len       <= '0;
            end else begin
                r_tag       <= n_tag;
                r_fmt       <= n_fmt;
                r_left      <= n_left;
                r_seen_fmt  <= n_seen_fmt;
                r_seen_data <= n_seen_data;
                r_err       <= n_err;
                r_next      <= n_next;
                r_start     <= n_start;
                r_len       <= n_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_item.end_of_file) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_item.end_of_file) begin
            r_out_status <= w_status;
            r_out_offset <= (w_status == ST_OK) ? n_start : 32'd0;
            r_out_size   <= (w_status == ST_OK) ? n_len : 32'd0;
        end
    end

    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= FMT_BODY_BYTES)
        else $error("fmt byte count out of range");

    a_clear_at_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_item.end_of_file |=>
            r_left == 5'd0 && !r_seen_fmt && !r_seen_data && r_err == ST_OK
            && r_next == FIRST_CHUNK)
        else $error("walk state not cleared after last byte");

    a_err_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status != ST_OK |->
            r_out_offset == 32'd0 && r_out_size == 32'd0)
        else $error("error result carries data fields");

    a_sticky_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err != ST_OK && !(o_pop && i_item.end_of_file) |=> $stable(r_err))
        else $error("first error overwritten");

endmodule

`default_nettype wire

/* src/wav_header_chunk_checker.sv */
// ---------------------------------------------------------------------------
// wav_header_chunk_checker
// Checks the RIFF/WAVE header and chunk list of a WAV file streamed a byte
// at a time and reports status, data chunk offset and data chunk size.
//
// Usage:
//   i_in carries one file byte per transaction, end_of_file set on the last.
//   o_out carries one result transaction per file, made on its last byte.
//   Configuration writes on i_cfg_we/i_cfg_idx/i_cfg_data set the expected
//   PCM format; write them only between files.
// Throughput: one byte per cycle while o_out takes each result. The front
//   counts positions, a two-entry queue feeds the back, which walks the
//   chunks and checks one byte per cycle through an add and compare for the
//   header position and an add for the next chunk start.
// Result path: the last byte is written into the queue, and the edge that
//   pops it from the queue loads the output register that drives o_out.
// Reset: synchronous, active low; clears the walk state and loads the
//   default format (1 channel, 44100 Hz, 88200 B/s, align 2, 16 bits).
// Stall: while o_out is held off the back keeps its result; the queue
//   fills and i_in.ready drops once it holds two bytes.
// ---------------------------------------------------------------------------
`default_nettype none

module wav_header_chunk_checker
    import wavh_pkg::*;
#(
    parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    wavh_in_if.sink     i_in,
    wavh_out_if.source  o_out,
    input  wire         i_cfg_we,
    input  wire [2:0]   i_cfg_idx,
    input  wire [31:0]  i_cfg_data
);

    localparam int Q_W = $bits(t_item) + LENGTH_WIDTH;

    t_cfg                    r_cfg;
    logic                    w_push;
    logic                    w_pop;
    logic                    w_full;
    logic                    w_q_valid;
    t_item                   w_in_item;
    t_item                   w_q_item;
    logic [LENGTH_WIDTH-1:0] w_in_pos;
    logic [LENGTH_WIDTH-1:0] w_q_pos;
    logic [Q_W-1:0]          w_q_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.channels    <= RST_CHANNELS;
            r_cfg.sample_rate <= RST_SAMPLE_RATE;
            r_cfg.byte_rate   <= RST_BYTE_RATE;
            r_cfg.frame_bytes <= RST_FRAME_BYTES;
            r_cfg.sample_bits <= RST_SAMPLE_BITS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CHANNELS: begin
                    r_cfg.channels <= i_cfg_data[15:0];
                end
                CFG_SAMPLE_RATE: begin
                    r_cfg.sample_rate <= i_cfg_data;
                end
                CFG_BYTE_RATE: begin
                    r_cfg.byte_rate <= i_cfg_data;
                end
                CFG_FRAME_BYTES: begin
                    r_cfg.frame_bytes <= i_cfg_data[15:0];
                end
                CFG_SAMPLE_BITS: begin
                    r_cfg.sample_bits <= i_cfg_data[15:0];
                end
                default: begin
                end
            endcase
        end
    end

    wavh_front #(
        .LENGTH_WIDTH(LENGTH_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_item   (w_in_item),
        .o_pos    (w_in_pos)
    );

    wavh_fifo #(
        .WIDTH(Q_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_in_pos, w_in_item}),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_data  (w_q_out)
    );

    assign w_q_item = w_q_out[$bits(t_item)-1:0];
    assign w_q_pos  = w_q_out[Q_W-1:$bits(t_item)];

    wavh_back #(
        .LENGTH_WIDTH(LENGTH_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (w_q_valid),
        .i_item    (w_q_item),
        .i_pos     (w_q_pos),
        .o_pop     (w_pop),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire
